// ===== sv/float_quantize_saturate_int_assert.svh =====
// Assertion macros for the float quantizer.
`ifndef FLOAT_QUANTIZE_SATURATE_INT_ASSERT_SVH
`define FLOAT_QUANTIZE_SATURATE_INT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FQS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define FQS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/fqs_pkg.sv =====
// Package for the float quantizer: constants and shared types.
package fqs_pkg;
  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam int unsigned STAGES = 4;
  typedef enum logic {CFG_SCALE = 1'b0, CFG_NARROW = 1'b1} cfg_idx_t;
  localparam logic signed [15:0] LIM16_HI = 16'sd32767;
  localparam logic signed [15:0] LIM16_LO = -16'sd32768;
  localparam logic signed [15:0] LIM8_HI  = 16'sd127;
  localparam logic signed [15:0] LIM8_LO  = -16'sd127;
  // Item class after the multiply.
  typedef enum logic [1:0] {K_NUM = 2'd0, K_ZERO = 2'd1, K_SAT = 2'd2, K_NAN = 2'd3} kind_t;
endpackage

// ===== sv/float_quantize_saturate_int.sv =====
// Top level: float32 times scale, round half away, saturate to int16/int8.
//
//  channel | direction | transfer payload
//  in_     | slave     | tdata[31:0] sample_bits, tlast last_in
//  out_    | master    | tdata[15:0] quantized (signed), tlast last_out
//  cfg_    | slave     | index 0 scale_bits, 1 narrow_mode; data 32 bits
//
// Four-stage pipeline, one transfer per cycle while the output is not stalled.
// Stage 1 unpacks and multiplies mantissas (24x24), stage 2 normalizes and
// rounds the product to float32, stage 3 aligns to an integer with guard bit,
// stage 4 rounds half away from zero and saturates.
// Synchronous active-low reset clears all valid bits; config resets to 1.0 and
// 16-bit mode. All stages advance together when the output stage is free.
module float_quantize_saturate_int
  import fqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_bits
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] quantized
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
`include "float_quantize_saturate_int_assert.svh"

  logic [31:0] scale_r;
  logic        narrow_r;
  logic [STAGES-1:0] vld_r;
  logic        adv;

  assign adv       = !vld_r[STAGES-1] || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      narrow_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE:  scale_r  <= cfg_data;
        CFG_NARROW: narrow_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[STAGES-2:0], in_tvalid};
  end

  // ---------------- stage 1: unpack, special cases, mantissa multiply
  logic        a_s_nxt, a_s_r;
  kind_t       a_k_nxt, a_k_r;
  logic signed [10:0] a_e_nxt, a_e_r;  // unbiased-ish sum of exponents
  logic [47:0] a_m_nxt, a_m_r;
  logic        a_l_r;
  always_comb begin
    logic [7:0] ex, es;
    logic [23:0] mx, ms;
    logic xz, sz, xi, si, xn, sn;
    ex = in_tdata[30:23]; es = scale_r[30:23];
    xz = (ex == 8'd0); sz = (es == 8'd0);
    mx = {!xz, in_tdata[22:0]}; ms = {!sz, scale_r[22:0]};
    xi = (ex == 8'hFF) && (in_tdata[22:0] == 23'd0);
    si = (es == 8'hFF) && (scale_r[22:0] == 23'd0);
    xn = (ex == 8'hFF) && !xi; sn = (es == 8'hFF) && !si;
    a_s_nxt = in_tdata[31] ^ scale_r[31];
    a_m_nxt = mx * ms;
    a_e_nxt = $signed({3'b0, xz ? 8'd1 : ex}) + $signed({3'b0, sz ? 8'd1 : es})
              - 11'sd127;
    if (xn || sn || (xi && (scale_r[30:0] == 31'd0)) || (si && (in_tdata[30:0] == 31'd0)))
      a_k_nxt = K_NAN;
    else if (xi || si) a_k_nxt = K_SAT;
    else a_k_nxt = K_NUM;
  end
  always_ff @(posedge clk) if (adv) begin
    a_s_r <= a_s_nxt; a_k_r <= a_k_nxt; a_e_r <= a_e_nxt; a_m_r <= a_m_nxt;
    a_l_r <= in_tlast;
  end

  // ---------------- stage 2: normalize and round to float32
  // Value = m * 2^(e-127-46). Only results >= 2^-1 matter; tiny products give 0,
  // huge ones (biased exponent >= 127+16) saturate. Subnormal rounding never
  // reaches 0.5, so a flush to zero is exact here. A subnormal operand leaves
  // leading zeros in m; the leading-zero count normalizes it.
  logic        b_s_r;
  kind_t       b_k_nxt, b_k_r;
  logic [4:0]  b_e_nxt, b_e_r;   // unbiased exponent 0..15 (or -1 mapped)
  logic        b_h_nxt, b_h_r;   // value in [0.5,1)
  logic [23:0] b_m_nxt, b_m_r;
  logic        b_l_r;
  always_comb begin
    logic [47:0] nm;
    logic signed [10:0] ue;
    logic [24:0] rm;
    logic [5:0] lz;
    logic lsb, g, st;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) if (a_m_r[i]) lz = 6'(47 - i);
    nm = a_m_r << lz;
    ue = a_e_r - 11'sd126 - $signed({5'd0, lz});
    lsb = nm[24]; g = nm[23]; st = |nm[22:0];
    rm = {1'b0, nm[47:24]} + {24'd0, g && (st || lsb)};
    if (rm[24]) begin rm = rm >> 1; ue = ue + 11'sd1; end
    b_m_nxt = rm[23:0];
    b_e_nxt = ue[4:0];
    b_h_nxt = (ue == -11'sd1);
    b_k_nxt = a_k_r;
    if (a_k_r == K_NUM) begin
      if (a_m_r == 48'd0) b_k_nxt = K_ZERO;
      else if (ue < -11'sd1) b_k_nxt = K_ZERO;
      else if (ue > 11'sd15) b_k_nxt = K_SAT;
    end
  end
  always_ff @(posedge clk) if (adv) begin
    b_s_r <= a_s_r; b_k_r <= b_k_nxt; b_e_r <= b_e_nxt; b_h_r <= b_h_nxt;
    b_m_r <= b_m_nxt; b_l_r <= a_l_r;
  end

  // ---------------- stage 3: shift to integer with half bit
  logic        c_s_r;
  kind_t       c_k_r;
  logic [16:0] c_i_nxt, c_i_r;   // magnitude * 2, bit0 = half
  logic        c_l_r;
  always_comb begin
    logic [38:0] w;
    w = {15'd0, b_m_r} << b_e_r;  // integer part at [38:23], half at [22]
    c_i_nxt = b_h_r ? 17'd1 : w[38:22];
  end
  always_ff @(posedge clk) if (adv) begin
    c_s_r <= b_s_r; c_k_r <= b_k_r; c_i_r <= c_i_nxt; c_l_r <= b_l_r;
  end

  // ---------------- stage 4: round away, saturate
  logic signed [15:0] d_q_nxt, d_q_r;
  logic        d_l_r;
  always_comb begin
    logic [16:0] mag;
    logic signed [15:0] hi, lo;
    hi = narrow_r ? LIM8_HI : LIM16_HI;
    lo = narrow_r ? LIM8_LO : LIM16_LO;
    mag = {1'b0, c_i_r[16:1]} + {16'd0, c_i_r[0]};
    unique case (c_k_r)
      K_NAN:  d_q_nxt = lo;
      K_ZERO: d_q_nxt = 16'sd0;
      K_SAT:  d_q_nxt = c_s_r ? lo : hi;
      default: begin
        if (c_s_r) d_q_nxt = (mag >= {1'b0, -lo}) ? lo : -$signed(mag[15:0]);
        else       d_q_nxt = (mag >= {1'b0, hi}) ? hi : $signed(mag[15:0]);
      end
    endcase
  end
  always_ff @(posedge clk) if (adv) begin
    d_q_r <= d_q_nxt; d_l_r <= c_l_r;
  end

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = d_q_r;
  assign out_tlast  = d_l_r;

  `FQS_ASSERT_IMP(a_ready, !out_tvalid, in_tready)
  `FQS_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `FQS_ASSERT_IMP(a_narrow, out_tvalid && narrow_r,
    ($signed(out_tdata) <= 16'sd127) && ($signed(out_tdata) >= -16'sd127))
endmodule

// ===== test/float_quantize_saturate_int_chk.sv =====
// Checker for the float quantizer: watches all channels, predicts and compares results.
module float_quantize_saturate_int_chk
  import fqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic signed [15:0] quantized;
    logic               last;
  } quant_result_t;

  logic [31:0]   scale_reg;
  logic          narrow_reg;
  quant_result_t expected_q[$];

  // binary32 multiply with round-to-nearest-even, then round half away and saturate
  function automatic logic signed [15:0] quantize_sample(logic [31:0] x, logic [31:0] s,
                                                          logic narrow);
    logic               sp, xnan, snan, xinf, sinf, xzero, szero;
    longint             mx, ms, prod, q, rem, half, mag, rv;
    int                 e, n, sh, f;
    logic signed [15:0] lo, hi;
    lo = narrow ? LIM8_LO : LIM16_LO;
    hi = narrow ? LIM8_HI : LIM16_HI;
    sp = x[31] ^ s[31];
    xnan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
    snan = (s[30:23] == 8'hFF) && (s[22:0] != 0);
    xinf = (x[30:23] == 8'hFF) && (x[22:0] == 0);
    sinf = (s[30:23] == 8'hFF) && (s[22:0] == 0);
    xzero = (x[30:0] == 0);
    szero = (s[30:0] == 0);
    if (xnan || snan || (xinf && szero) || (sinf && xzero)) return lo;
    if (xinf || sinf) return sp ? lo : hi;
    if (xzero || szero) return 16'sd0;
    mx = (x[30:23] == 0) ? longint'(x[22:0]) : longint'({1'b1, x[22:0]});
    ms = (s[30:23] == 0) ? longint'(s[22:0]) : longint'({1'b1, s[22:0]});
    e = ((x[30:23] == 0) ? 1 : int'(x[30:23])) + ((s[30:23] == 0) ? 1 : int'(s[30:23])) - 300;
    prod = mx * ms;
    n = 47;
    while (!prod[n]) n--;
    // normal results keep 24 bits, tiny ones keep bits down to 2^-149
    sh = (n + e >= -126) ? n - 23 : -149 - e;
    if (sh > 0) begin
      if (sh > 50) begin
        q = 0;
      end else begin
        q = prod >> sh;
        rem = prod & ((longint'(1) << sh) - 1);
        half = longint'(1) << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
      end
      f = e + sh;
    end else begin
      q = prod;
      f = e;
    end
    if (q == 0) mag = 0;
    else if (f >= 16) mag = longint'(1) << 20;
    else if (f >= 0) mag = q << f;
    else if (-f > 40) mag = 0;
    else mag = (q + (longint'(1) << (-f - 1))) >> (-f);
    rv = sp ? -mag : mag;
    if (rv > hi) rv = hi;
    if (rv < lo) rv = lo;
    return rv[15:0];
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    quant_result_t exp_r;
    if (!rst_n) begin
      scale_reg <= SCALE_RESET;
      narrow_reg <= 1'b0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SCALE:  scale_reg <= cfg_data;
          CFG_NARROW: narrow_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.push_back('{quantize_sample(in_tdata, scale_reg, narrow_reg), in_tlast});
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual q=%0d last=%0b",
                   $time, $signed(out_tdata), out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata !== exp_r.quantized || out_tlast !== exp_r.last) begin
            $display("%0t: expected q=%0d last=%0b, actual q=%0d last=%0b", $time,
                     exp_r.quantized, exp_r.last, $signed(out_tdata), out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/float_quantize_saturate_int_tb.sv =====
// Testbench top for the float quantizer: stimulus, receiver stalls, watchdog and verdict.
module float_quantize_saturate_int_tb;
  import fqs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] sample_bits
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] quantized
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  // idle rates in percent; hold_len starts a long receiver stall
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 48;
  int unsigned hold_len = 0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk = ~clk;

  float_quantize_saturate_int uut (.*);

  float_quantize_saturate_int_chk chk (.*);

  // Receiver: random back-pressure, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 3000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One input transfer; valid stays high into the next item unless we idle.
  task automatic send_sample(logic [31:0] bits, logic last);
    in_tvalid <= 1'b1;
    in_tdata <= bits;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result is back.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // pipeline is four deep
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly values whose product lands near the integer range; exact halves
  // come from clearing low mantissa bits. Some noise and special encodings.
  function automatic logic [31:0] rand_sample();
    logic [31:0] b;
    int unsigned sel;
    sel = $urandom_range(99);
    b = $urandom;
    if (sel < 60) begin
      b[30:23] = 8'($urandom_range(145, 110));
      if ($urandom_range(2) == 0) b[22:0] = b[22:0] & (23'h7FFFFF << $urandom_range(22, 8));
    end else if (sel < 70) begin
      b[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(1)) b[22:0] = '0;
    end
    return b;
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_sample(rand_sample(), 1'($urandom_range(1)));
  endtask

  logic [31:0] directed[$] = '{
    32'h0000_0000, 32'h8000_0000,   // both zeros
    32'h4020_0000, 32'hC020_0000,   // 2.5 / -2.5, halves go away from zero
    32'h3F00_0000, 32'hBF00_0000,   // 0.5 / -0.5
    32'h3FC0_0000, 32'h3EFF_FFFF,   // 1.5, just under half
    32'h46FF_FE00, 32'h46FF_FF00,   // 32767.0, 32767.5 saturates
    32'hC700_0000, 32'hC700_0080,   // -32768, -32768.5
    32'hC6FF_FF33, 32'h4974_2400,   // -32767.6, 1e6
    32'h7F80_0000, 32'hFF80_0000,   // infinities
    32'h7FC0_0000, 32'hFFFF_FFFF,   // NaNs
    32'h0000_0001, 32'h807F_FFFF,   // subnormals
    32'h7F7F_FFFF, 32'hFF7F_FFFF,   // largest finite
    32'hC300_0000, 32'hC2FF_0000,   // -128, -127.5 (banned in 8-bit mode)
    32'h42FF_3333                    // 127.6
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edge values in both saturation modes at scale 1.0.
    foreach (directed[i]) send_sample(directed[i], i[0]);
    write_reg(CFG_NARROW, 32'd1);
    foreach (directed[i]) send_sample(directed[i], i[0]);

    // First idle pattern.
    write_reg(CFG_SCALE, 32'h3E00_0000);           // 0.125
    run_random(250);
    write_reg(CFG_NARROW, 32'd0);
    write_reg(CFG_SCALE, 32'h4180_0000);           // 16.0
    run_random(200);

    // Second idle pattern, with a long receiver hold-off and a sender pause.
    send_idle_pct = 48;
    recv_idle_pct = 25;
    write_reg(CFG_SCALE, {1'b1, 8'd127, 23'($urandom)});
    send_idle_pct = 0;
    hold_len = 300;
    run_random(100);
    send_idle_pct = 48;
    drain();
    run_random(150);
    write_reg(CFG_NARROW, 32'd1);
    run_random(200);

    // Extreme scales: tiny, huge, NaN, infinity, negative zero.
    write_reg(CFG_SCALE, 32'h0000_0001);
    foreach (directed[i]) send_sample(directed[i], 1'b0);
    write_reg(CFG_SCALE, 32'h7F7F_FFFF);
    run_random(20);
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    run_random(20);
    write_reg(CFG_NARROW, 32'd0);
    write_reg(CFG_SCALE, 32'h7F80_0000);
    foreach (directed[i]) send_sample(directed[i], 1'b1);
    write_reg(CFG_SCALE, 32'h8000_0000);
    foreach (directed[i]) send_sample(directed[i], 1'b0);

    // No idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SCALE, 32'h3F80_0000);
    run_random(250);
    write_reg(CFG_NARROW, 32'd1);
    write_reg(CFG_SCALE, 32'h3C00_0000);           // 1/128
    run_random(250);

    drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
